// ===== rtl/core/lras_pkg.sv =====
// ----------------------------------------------------------------------------
// lras_pkg
// Shared types and constants for the lazy range-add / range-sum tree.
// ----------------------------------------------------------------------------
package lras_pkg;

	localparam int LEAVES = 1024;
	localparam int LVL = $clog2(LEAVES);
	localparam int TSIZE = 1 << LVL;
	localparam int NODES = 2 * TSIZE - 1;
	localparam int NW = $clog2(NODES);
	localparam int CW = LVL + 1;
	localparam int HW = $clog2(LVL + 1);
	localparam int SPW = $clog2(LVL + 1);

	localparam logic [1:0] OP_SET = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_SUM = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_VISIT,
		ST_RD_NODE,
		ST_PUSH_L,
		ST_PUSH_R,
		ST_POP,
		ST_FIX_UP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [NW-1:0] node;
		logic [CW-1:0] lo;
		logic [CW-1:0] hi;
		logic [HW-1:0] ht;
		logic          second;
	} frame_t;

endpackage

// ===== rtl/core/lras_mem.sv =====
// ----------------------------------------------------------------------------
// lras_mem
// Node memory: sum and pending add per tree node, one write port and two
// registered read ports.
// ----------------------------------------------------------------------------
module lras_mem import lras_pkg::*; (
	input  logic                 clk,
	input  logic                 we,
	input  logic [NW-1:0]        waddr,
	input  logic [127:0]         wdata,
	input  logic [NW-1:0]        raddr_a,
	input  logic [NW-1:0]        raddr_b,
	output logic [127:0]         rdata_a,
	output logic [127:0]         rdata_b
);

	logic [127:0] mem [NODES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/core/lazy_range_add_sum_tree.sv =====
// ----------------------------------------------------------------------------
// lazy_range_add_sum_tree
// Point set, range-add and range-sum over 1024 signed 64-bit elements in a lazy sum tree.
// ----------------------------------------------------------------------------
// After reset the block clears its node memory, one node a cycle (all 2047
// nodes), before the first word is taken. Each operation walks the tree
// iteratively with an explicit stack, all through the one write port of the
// node memory. A node outside the range is only visited, a node fully inside
// the range is also read (and written for a set or an add), and a split node
// is read, has its pending add pushed to both children and, but for a query,
// its sum written back on the way up. An empty range or an unused opcode ends
// without a walk; an empty query returns a sum of zero. One operation is worked
// at a time; a query result waits in an output register while the next word
// is taken.
module lazy_range_add_sum_tree import lras_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          opcode,
	input  logic [9:0]          position,
	input  logic [10:0]         range_start,
	input  logic [10:0]         range_end,
	input  logic signed [63:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [63:0]  range_sum
);

	state_t state_q, state_d;
	frame_t stk_q [LVL];
	logic [SPW-1:0] sp_q, top_idx;
	frame_t cur_q, top;
	logic [1:0] op_q;
	logic [CW-1:0] l_q, r_q;
	logic [63:0] v_q, acc_q, sum_q, pend_q;
	logic [NW-1:0] clr_q;
	logic out_valid_q;

	logic we;
	logic [NW-1:0] waddr, ra, rb;
	logic [127:0] wdata, da, db;

	logic [CW-1:0] mid, top_mid;
	logic [NW-1:0] kl, kr, top_kl, top_kr;
	logic outside, covered, ok_in, load_out;
	logic [10:0] lcl, rcl;

	lras_mem u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(ra), .raddr_b(rb), .rdata_a(da), .rdata_b(db)
	);

	assign top_idx = (sp_q == '0) ? '0 : sp_q - 1'b1;
	assign top = stk_q[top_idx];

	assign mid = cur_q.lo + (CW'(1) << (cur_q.ht - 1'b1));
	assign top_mid = top.lo + (CW'(1) << (top.ht - 1'b1));
	assign kl = NW'({cur_q.node, 1'b1});
	assign kr = NW'({cur_q.node, 1'b0}) + NW'(2);
	assign top_kl = NW'({top.node, 1'b1});
	assign top_kr = NW'({top.node, 1'b0}) + NW'(2);
	assign outside = (cur_q.hi <= l_q) || (r_q <= cur_q.lo);
	assign covered = (l_q <= cur_q.lo) && (cur_q.hi <= r_q);
	assign lcl = (range_start > 11'(LEAVES)) ? 11'(LEAVES) : range_start;
	assign rcl = (range_end > 11'(LEAVES)) ? 11'(LEAVES) : range_end;

	assign ok_in = (opcode == OP_SET) ? (11'(position) < 11'(LEAVES)) :
	               (opcode == OP_ADD || opcode == OP_SUM) ? (lcl < rcl) : 1'b0;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign range_sum = sum_q;

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = cur_q.node;
		wdata = '0;
		ra = cur_q.node;
		rb = kr;
		load_out = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				waddr = clr_q;
				if (clr_q == NW'(NODES - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (ok_in) state_d = ST_VISIT;
					else if (opcode == OP_SUM) state_d = ST_OUT;
				end
			end
			ST_VISIT: begin
				if (outside) state_d = ST_POP;
				else state_d = ST_RD_NODE;
			end
			ST_RD_NODE: begin
				ra = kl;
				rb = kr;
				if (covered) begin
					state_d = ST_POP;
					if (op_q == OP_SET) begin
						we = 1'b1;
						wdata = {da[127:64], v_q};
					end else if (op_q == OP_ADD) begin
						we = 1'b1;
						wdata = {da[127:64] + v_q, da[63:0] + (v_q << cur_q.ht)};
					end
				end else begin
					// split node: clear its pending add, children get it next
					we = 1'b1;
					wdata = {64'd0, da[63:0]};
					state_d = ST_PUSH_L;
				end
			end
			ST_PUSH_L: begin
				we = 1'b1;
				waddr = kl;
				rb = kr;
				wdata = {da[127:64] + pend_q, da[63:0] + (pend_q << (cur_q.ht - 1'b1))};
				state_d = ST_PUSH_R;
			end
			ST_PUSH_R: begin
				we = 1'b1;
				waddr = kr;
				wdata = {db[127:64] + pend_q, db[63:0] + (pend_q << (cur_q.ht - 1'b1))};
				state_d = ST_VISIT;
			end
			ST_POP: begin
				ra = top_kl;
				rb = top_kr;
				if (sp_q == '0) state_d = (op_q == OP_SUM) ? ST_OUT : ST_IDLE;
				else if (!top.second) state_d = ST_VISIT;
				else if (op_q == OP_SUM) state_d = ST_POP;
				else state_d = ST_FIX_UP;
			end
			ST_FIX_UP: begin
				we = 1'b1;
				wdata = {64'd0, da[63:0] + db[63:0]};
				state_d = ST_POP;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			sp_q <= '0;
			cur_q <= '0;
			op_q <= '0;
			l_q <= '0;
			r_q <= '0;
			v_q <= '0;
			acc_q <= '0;
			pend_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (in_valid) begin
						op_q <= opcode;
						l_q <= (opcode == OP_SET) ? CW'(position) : CW'(lcl);
						r_q <= (opcode == OP_SET) ? CW'(position) + CW'(1) : CW'(rcl);
						v_q <= value;
						acc_q <= '0;
						sp_q <= '0;
						cur_q <= '{node: '0, lo: '0, hi: CW'(TSIZE), ht: HW'(LVL),
						           second: 1'b0};
					end
				end
				ST_RD_NODE: begin
					if (covered) begin
						if (op_q == OP_SUM) acc_q <= acc_q + da[63:0];
					end else begin
						pend_q <= da[127:64];
					end
				end
				ST_PUSH_R: begin
					sp_q <= sp_q + 1'b1;
					cur_q <= '{node: kl, lo: cur_q.lo, hi: mid, ht: cur_q.ht - 1'b1,
					           second: 1'b0};
				end
				ST_POP: begin
					if (sp_q != '0) begin
						if (!top.second) begin
							cur_q <= '{node: top_kr, lo: top_mid, hi: top.hi,
							           ht: top.ht - 1'b1, second: 1'b0};
						end else begin
							sp_q <= sp_q - 1'b1;
							cur_q <= top;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// walk stack
	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH_R) begin
			stk_q[sp_q] <= '{node: cur_q.node, lo: cur_q.lo, hi: cur_q.hi, ht: cur_q.ht,
			                 second: 1'b0};
		end else if (state_q == ST_POP && sp_q != '0 && !top.second) begin
			stk_q[top_idx].second <= 1'b1;
		end
	end

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sum_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				sum_q <= acc_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives set, range-add and range-sum words into the lazy sum tree with random
// gaps and output stalls, and checks every sum against a flat-array model.
// ----------------------------------------------------------------------------
module testbench import lras_pkg::*;;

	typedef struct {
		logic [1:0]         op;
		logic [9:0]         pos;
		logic [10:0]        lo;
		logic [10:0]        hi;
		logic signed [63:0] val;
	} word_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         opcode;
	logic [9:0]         position;
	logic [10:0]        range_start;
	logic [10:0]        range_end;
	logic signed [63:0] value;
	logic               out_valid;
	logic               out_ready;
	logic signed [63:0] range_sum;

	lazy_range_add_sum_tree dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .position(position),
		.range_start(range_start), .range_end(range_end), .value(value),
		.out_valid(out_valid), .out_ready(out_ready), .range_sum(range_sum)
	);

	logic [63:0] elems[LEAVES];
	word_t       pending_words[$];
	logic [63:0] expected_sums[$];
	int          mismatches = 0;
	int          in_gap = 0;
	int          out_gap = 0;
	int          hold_off = 0;
	bit          stim_done = 0;
	bit          pause_req = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// flat array model of the tree
	task automatic apply_word(input word_t w);
		int unsigned l;
		int unsigned r;
		logic [63:0] acc;
		l = (w.lo > LEAVES) ? LEAVES : w.lo;
		r = (w.hi > LEAVES) ? LEAVES : w.hi;
		acc = '0;
		case (w.op)
			OP_SET: begin
				if (w.pos < LEAVES)
					elems[w.pos] = w.val;
			end
			OP_ADD: begin
				for (int i = l; i < r; i++)
					elems[i] = elems[i] + w.val;
			end
			OP_SUM: begin
				for (int i = l; i < r; i++)
					acc = acc + elems[i];
				expected_sums.push_back(acc);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= '0;
			position <= '0;
			range_start <= '0;
			range_end <= '0;
			value <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				apply_word(pending_words.pop_front());
			end
			if (!(in_valid && !in_ready)) begin
				if (in_valid && in_ready) begin
					in_gap <= $urandom_range(0, 14);
					in_valid <= 1'b0;
				end else if (in_gap > 0) begin
					in_gap <= in_gap - 1;
				end else if (pending_words.size() > 0 && !pause_req) begin
					in_valid <= 1'b1;
					opcode <= pending_words[0].op;
					position <= pending_words[0].pos;
					range_start <= pending_words[0].lo;
					range_end <= pending_words[0].hi;
					value <= pending_words[0].val;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_sums.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected sum %0d", range_sum);
				end else begin
					logic [63:0] e;
					e = expected_sums.pop_front();
					if (e !== range_sum) begin
						mismatches++;
						if (mismatches <= 10)
							$display("sum mismatch: expected %0d got %0d",
								$signed(e), range_sum);
					end
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else if (out_valid && out_ready) begin
				out_gap <= $urandom_range(0, 14);
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [10:0] rand_bound();
		case ($urandom_range(0, 5))
			0: return 11'd0;
			1: return 11'd1024;
			2: return 11'(2047 - $urandom_range(0, 1022));
			default: return 11'($urandom_range(0, 1024));
		endcase
	endfunction

	function automatic logic signed [63:0] rand_value();
		case ($urandom_range(0, 4))
			0: return 64'sh8000000000000000;
			1: return 64'sh7fffffffffffffff;
			2: return 64'($signed($urandom_range(0, 200)) - 100);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic queue_word(input logic [1:0] op, input logic [9:0] p,
		input logic [10:0] l, input logic [10:0] r, input logic signed [63:0] v);
		word_t w;
		w.op = op;
		w.pos = p;
		w.lo = l;
		w.hi = r;
		w.val = v;
		pending_words.push_back(w);
	endtask

	initial begin
		logic [1:0] op;
		for (int i = 0; i < LEAVES; i++)
			elems[i] = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		queue_word(OP_SUM, 0, 0, 1024, 0);
		queue_word(OP_SET, 0, 0, 0, 64'sh7fffffffffffffff);
		queue_word(OP_SET, 1023, 0, 0, 64'sh8000000000000000);
		queue_word(OP_SET, 512, 2047, 2047, -1);
		queue_word(OP_SUM, 0, 0, 1024, 0);
		queue_word(OP_ADD, 0, 0, 1024, 64'sh5555555555555555);
		queue_word(OP_ADD, 0, 1000, 2047, -7);
		queue_word(OP_ADD, 0, 300, 100, 99);
		queue_word(OP_ADD, 0, 5, 5, 99);
		queue_word(OP_SUM, 0, 0, 1, 0);
		queue_word(OP_SUM, 0, 1023, 1024, 0);
		queue_word(OP_SUM, 0, 1020, 2047, 0);
		queue_word(OP_SUM, 0, 300, 100, 0);
		queue_word(OP_SUM, 0, 7, 7, 0);
		queue_word(OP_SUM, 0, 2047, 2047, 0);
		queue_word(OP_NOP, 10'h3ff, 11'h7ff, 11'h7ff, -1);
		queue_word(OP_SET, 10'h2aa, 0, 0, 64'shaaaaaaaaaaaaaaaa);
		queue_word(OP_SUM, 0, 11'h2aa, 11'h555, 0);
		queue_word(OP_SUM, 0, 511, 513, 0);

		// long output stall while inputs keep coming
		for (int i = 0; i < 20; i++)
			queue_word(OP_SUM, 0, rand_bound(), rand_bound(), 0);
		hold_off = 3000;
		wait (pending_words.size() == 0);
		wait (expected_sums.size() == 0);

		for (int i = 0; i < 730; i++) begin
			op = ($urandom_range(0, 19) == 0) ? OP_NOP : 2'($urandom_range(0, 2));
			queue_word(op, 10'($urandom), rand_bound(), rand_bound(), rand_value());
			if (i == 300) begin
				wait (pending_words.size() == 0);
				pause_req = 1'b1;
				wait (expected_sums.size() == 0);
				pause_req = 1'b0;
			end
		end
		wait (pending_words.size() == 0);
		wait (expected_sums.size() == 0);
		repeat (400) @(posedge clk);
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		if (mismatches == 0 && expected_sums.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("simulation failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/lras_pkg.sv
rtl/core/lras_mem.sv
rtl/core/lazy_range_add_sum_tree.sv
tb/sv/testbench.sv
